[src/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/cdq_pkg.sv]
// types and constants of the circular deque unit
package cdq_pkg;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int CAP_W     = 5;
    localparam int DEPTH_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic signed [DATA_W-1:0] EMPTY_WORD = '1;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] front_value;
        logic                     front_valid;
        logic signed [DATA_W-1:0] rear_value;
        logic                     rear_valid;
        logic                     is_empty;
        logic                     is_full;
        logic [CAP_W-1:0]         occupancy;
    } t_result;

endpackage

[src/cdq_ring_mem.sv]
// ring store: one write port, one read port with registered read data
module cdq_ring_mem
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/cdq_ctrl.sv]
// deque control: pointers, count, end-value cache and result register
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    output logic              o_res_valid,
    output t_result           o_result,
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output logic [DATA_W-1:0] o_mem_wdata,
    output logic              o_mem_re,
    output logic [AW-1:0]     o_mem_raddr,
    input  logic [DATA_W-1:0] i_mem_rdata
);

    localparam int PW = (AW > CAP_W) ? AW : CAP_W;

    typedef enum logic {S_IDLE, S_RESP} t_state;

    t_state                   r_state;
    logic [AW-1:0]            r_head, r_tail;
    logic [CAP_W-1:0]         r_cnt, r_cap;
    logic signed [DATA_W-1:0] r_front, r_rear;
    logic                     r_ok, r_sel_front, r_sel_rear;
    logic                     r_res_valid;
    t_result                  r_result;

    logic [AW-1:0]            n_head, n_tail;
    logic [CAP_W-1:0]         n_cnt;
    logic signed [DATA_W-1:0] n_front, n_rear;
    logic                     n_ok, n_sel_front, n_sel_rear;
    logic                     w_acc, w_we, w_re;
    logic [CAP_W-1:0]         w_cap;
    logic [PW-1:0]            w_cap_x, w_head_x, w_tail_x;
    logic [AW-1:0]            w_head_inc, w_head_dec, w_tail_inc, w_tail_dec;
    logic signed [DATA_W-1:0] w_front_now, w_rear_now;
    logic                     w_empty_now;

    // effective capacity
    always_comb begin
        if (r_cap == '0) begin
            w_cap = CAP_W'(1);
        end else if (32'(r_cap) > 32'(DEPTH)) begin
            w_cap = CAP_W'(DEPTH);
        end else begin
            w_cap = r_cap;
        end
    end

    assign w_cap_x  = PW'(w_cap);
    assign w_head_x = PW'(r_head);
    assign w_tail_x = PW'(r_tail);

    assign w_head_inc = (w_head_x + PW'(1) == w_cap_x) ? '0 : r_head + AW'(1);
    assign w_tail_inc = (w_tail_x + PW'(1) == w_cap_x) ? '0 : r_tail + AW'(1);
    assign w_head_dec = (r_head == '0) ? AW'(w_cap_x - PW'(1)) : r_head - AW'(1);
    assign w_tail_dec = (r_tail == '0) ? AW'(w_cap_x - PW'(1)) : r_tail - AW'(1);

    assign w_acc = start && (r_state == S_IDLE);

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_cnt       = r_cnt;
        n_front     = r_front;
        n_rear      = r_rear;
        n_ok        = 1'b0;
        n_sel_front = 1'b0;
        n_sel_rear  = 1'b0;
        w_we        = 1'b0;
        w_re        = 1'b0;
        case (i_item.cmd)
            CMD_INS_FRONT: begin
                if (r_cnt < w_cap) begin
                    if (r_cnt == '0) begin
                        n_head = '0;
                        n_tail = '0;
                        n_rear = i_item.value;
                    end else begin
                        n_head = w_head_dec;
                    end
                    n_front = i_item.value;
                    n_cnt   = r_cnt + CAP_W'(1);
                    w_we    = 1'b1;
                    n_ok    = 1'b1;
                end
            end
            CMD_INS_BACK: begin
                if (r_cnt < w_cap) begin
                    if (r_cnt == '0) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_front = i_item.value;
                    end else begin
                        n_tail = w_tail_inc;
                    end
                    n_rear = i_item.value;
                    n_cnt  = r_cnt + CAP_W'(1);
                    w_we   = 1'b1;
                    n_ok   = 1'b1;
                end
            end
            CMD_REM_FRONT: begin
                if (r_cnt != '0) begin
                    if (r_cnt == CAP_W'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                        n_cnt  = '0;
                    end else begin
                        n_head      = w_head_inc;
                        n_cnt       = r_cnt - CAP_W'(1);
                        w_re        = 1'b1;
                        n_sel_front = 1'b1;
                    end
                    n_ok = 1'b1;
                end
            end
            CMD_REM_BACK: begin
                if (r_cnt != '0) begin
                    if (r_cnt == CAP_W'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                        n_cnt  = '0;
                    end else begin
                        n_tail     = w_tail_dec;
                        n_cnt      = r_cnt - CAP_W'(1);
                        w_re       = 1'b1;
                        n_sel_rear = 1'b1;
                    end
                    n_ok = 1'b1;
                end
            end
            CMD_QUERY: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // ring store access, issued on the accept edge
    assign o_mem_we    = w_acc && w_we;
    assign o_mem_waddr = n_head == r_head ? n_tail : n_head;
    assign o_mem_wdata = i_item.value;
    assign o_mem_re    = w_acc && w_re;
    assign o_mem_raddr = n_sel_front ? n_head : n_tail;

    // end values once the read data has landed
    assign w_front_now = r_sel_front ? i_mem_rdata : r_front;
    assign w_rear_now  = r_sel_rear  ? i_mem_rdata : r_rear;
    assign w_empty_now = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_cnt       <= '0;
            r_cap       <= CAP_RESET;
            r_res_valid <= 1'b0;
            r_sel_front <= 1'b0;
            r_sel_rear  <= 1'b0;
            r_ok        <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_we) begin
                r_cap  <= i_cfg_wdata;
                r_head <= '0;
                r_tail <= '0;
                r_cnt  <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_head      <= n_head;
                        r_tail      <= n_tail;
                        r_cnt       <= n_cnt;
                        r_front     <= n_front;
                        r_rear      <= n_rear;
                        r_ok        <= n_ok;
                        r_sel_front <= n_sel_front;
                        r_sel_rear  <= n_sel_rear;
                        r_state     <= S_RESP;
                    end
                end
                S_RESP: begin
                    r_front                <= w_front_now;
                    r_rear                 <= w_rear_now;
                    r_result.ok            <= r_ok;
                    r_result.front_value   <= w_empty_now ? EMPTY_WORD : w_front_now;
                    r_result.front_valid   <= !w_empty_now;
                    r_result.rear_value    <= w_empty_now ? EMPTY_WORD : w_rear_now;
                    r_result.rear_valid    <= !w_empty_now;
                    r_result.is_empty      <= w_empty_now;
                    r_result.is_full       <= (r_cnt == w_cap);
                    r_result.occupancy     <= r_cnt;
                    r_res_valid            <= 1'b1;
                    r_state                <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state == S_RESP);
    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule

[src/circular_deque_unit.sv]
// circular deque unit: top level with ring store and control
//
// channel   | signals                    | handshake
// ----------+----------------------------+----------------------------------
// command   | start, busy, i_item        | taken when start and not busy
// result    | o_res_valid, o_result      | one-cycle strobe, no backpressure
// config    | i_cfg_we, i_cfg_wdata      | written when i_cfg_we is high
//
// per item: pointer update and ring store access at the accept edge, then
// the registered read data folds into the end-value cache
// busy is high in the cycle after the accept edge; the result strobe is
// high in the cycle after that, and a new item can be taken in that same
// cycle; no new item is taken while busy is high
// synchronous reset empties the deque and sets capacity to 16; no clearing pass
module circular_deque_unit
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item            i_item,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output logic             o_res_valid,
    output t_result          o_result
);

`include "assert_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              w_mem_we, w_mem_re;
    logic [AW-1:0]     w_mem_waddr, w_mem_raddr;
    logic [DATA_W-1:0] w_mem_wdata, w_mem_rdata;
    logic              w_res_empty, w_empty_clean;

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res_valid (o_res_valid),
        .o_result    (o_result),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    cdq_ring_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign w_res_empty   = o_res_valid && o_result.is_empty;
    assign w_empty_clean = (o_result.occupancy == '0) && !o_result.front_valid
                           && !o_result.rear_valid;

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_res_valid)
    `ASSERT_NEXT(a_busy_result, i_clk, i_rst_n, busy, o_res_valid && !busy)
    `ASSERT_IMPL(a_store_idle, i_clk, i_rst_n, w_mem_we || w_mem_re, !busy && start)
    `ASSERT_IMPL(a_empty_flags, i_clk, i_rst_n, w_res_empty, w_empty_clean)

endmodule
